/* design/jpe_pkg.sv */
// Shared types, constants and the microprogram of the Jacobi polynomial evaluator.
// Used by jpe_alu and jacobi_polynomial_evaluator; depends on nothing else.
package jpe_pkg;

  localparam int MAX_ORDER = 64;
  localparam int KW = $clog2(MAX_ORDER + 1);
  localparam int PC_W = 6;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_TWO = 64'h0000_0002_0000_0000;
  localparam logic [63:0] Q_HALF = 64'h0000_0000_8000_0000;

  localparam logic [PC_W-1:0] L_PASS1 = PC_W'(7);
  localparam logic [PC_W-1:0] L_ONE = PC_W'(11);
  localparam logic [PC_W-1:0] L_INIT = PC_W'(12);
  localparam logic [PC_W-1:0] L_STEP = PC_W'(19);
  localparam logic [PC_W-1:0] L_SLOPE = PC_W'(49);

  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA = 1'b1;

  typedef enum logic [2:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV
  } op_t;

  typedef enum logic [4:0] {
    RG_ZERO, RG_ONE, RG_TWO, RG_HALF, RG_X, RG_A, RG_B, RG_AB,
    RG_P0, RG_P1, RG_KQ, RG_S, RG_S1, RG_S2, RG_T1, RG_T2,
    RG_AN1, RG_AN2, RG_AN3, RG_AN4, RG_C1, RG_C2, RG_SLOPE
  } reg_t;

  typedef enum logic [3:0] {
    IM_ZERO, IM_ONE, IM_TWO, IM_HALF, IM_X, IM_ACFG, IM_BCFG,
    IM_KQ, IM_K2, IM_K12, IM_NQ
  } imm_t;

  typedef enum logic [2:0] {
    BR_NONE, BR_SETUP, BR_INIT, BR_STEP, BR_PASS, BR_END
  } br_t;

  typedef struct packed {
    op_t  op;
    reg_t dst;
    reg_t sa;
    reg_t sb;
    imm_t imm;
    br_t  br;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_ISSUE, ST_WAIT, ST_NEXT, ST_DONE
  } state_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat_res_t;

  function automatic logic [63:0] mag_of(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Signs a magnitude and clips it to the signed 64-bit range.
  function automatic sat_res_t from_mag(logic neg, logic [63:0] mag);
    sat_res_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag[63]) begin
        r.sat = 1'b1;
        r.val = Q_MAX;
      end else begin
        r.val = mag;
      end
    end else if (mag > Q_MIN) begin
      r.sat = 1'b1;
      r.val = Q_MIN;
    end else begin
      r.val = 64'd0 - mag;
    end
    return r;
  endfunction

  function automatic uop_t ld(reg_t dst, imm_t imm, br_t br);
    uop_t u;
    u.op = OP_LD;
    u.dst = dst;
    u.sa = RG_ZERO;
    u.sb = RG_ZERO;
    u.imm = imm;
    u.br = br;
    return u;
  endfunction

  function automatic uop_t al(op_t op, reg_t dst, reg_t sa, reg_t sb, br_t br);
    uop_t u;
    u.op = op;
    u.dst = dst;
    u.sa = sa;
    u.sb = sb;
    u.imm = IM_ZERO;
    u.br = br;
    return u;
  endfunction

  // Microprogram: constants and pass setup, init of P0/P1, one recurrence step, slope.
  function automatic uop_t prog(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = ld(RG_ZERO, IM_ZERO, BR_NONE);
      6'd1:  u = ld(RG_ONE, IM_ONE, BR_NONE);
      6'd2:  u = ld(RG_TWO, IM_TWO, BR_NONE);
      6'd3:  u = ld(RG_HALF, IM_HALF, BR_NONE);
      6'd4:  u = ld(RG_X, IM_X, BR_NONE);
      6'd5:  u = ld(RG_A, IM_ACFG, BR_NONE);
      6'd6:  u = ld(RG_B, IM_BCFG, BR_SETUP);
      6'd7:  u = ld(RG_A, IM_ACFG, BR_NONE);
      6'd8:  u = ld(RG_B, IM_BCFG, BR_NONE);
      6'd9:  u = al(OP_ADD, RG_A, RG_A, RG_ONE, BR_NONE);
      6'd10: u = al(OP_ADD, RG_B, RG_B, RG_ONE, BR_SETUP);
      6'd11: u = ld(RG_P1, IM_ONE, BR_PASS);
      6'd12: u = al(OP_ADD, RG_AB, RG_A, RG_B, BR_NONE);
      6'd13: u = al(OP_SUB, RG_T1, RG_A, RG_B, BR_NONE);
      6'd14: u = al(OP_ADD, RG_T2, RG_AB, RG_TWO, BR_NONE);
      6'd15: u = al(OP_MUL, RG_T2, RG_T2, RG_X, BR_NONE);
      6'd16: u = al(OP_ADD, RG_T1, RG_T1, RG_T2, BR_NONE);
      6'd17: u = al(OP_MUL, RG_P1, RG_HALF, RG_T1, BR_NONE);
      6'd18: u = al(OP_ADD, RG_P0, RG_ONE, RG_ZERO, BR_INIT);
      6'd19: u = ld(RG_KQ, IM_KQ, BR_NONE);
      6'd20: u = ld(RG_T1, IM_K2, BR_NONE);
      6'd21: u = al(OP_ADD, RG_S, RG_T1, RG_AB, BR_NONE);
      6'd22: u = al(OP_ADD, RG_S1, RG_S, RG_ONE, BR_NONE);
      6'd23: u = al(OP_ADD, RG_S2, RG_S, RG_TWO, BR_NONE);
      6'd24: u = al(OP_ADD, RG_T2, RG_KQ, RG_A, BR_NONE);
      6'd25: u = al(OP_ADD, RG_T1, RG_KQ, RG_AB, BR_NONE);
      6'd26: u = al(OP_ADD, RG_T1, RG_T1, RG_ONE, BR_NONE);
      6'd27: u = ld(RG_AN1, IM_K12, BR_NONE);
      6'd28: u = al(OP_MUL, RG_AN1, RG_AN1, RG_T1, BR_NONE);
      6'd29: u = al(OP_MUL, RG_AN1, RG_AN1, RG_S, BR_NONE);
      6'd30: u = al(OP_MUL, RG_T1, RG_A, RG_A, BR_NONE);
      6'd31: u = al(OP_MUL, RG_AN2, RG_B, RG_B, BR_NONE);
      6'd32: u = al(OP_SUB, RG_AN2, RG_T1, RG_AN2, BR_NONE);
      6'd33: u = al(OP_MUL, RG_AN2, RG_S1, RG_AN2, BR_NONE);
      6'd34: u = al(OP_MUL, RG_AN3, RG_S, RG_S1, BR_NONE);
      6'd35: u = al(OP_MUL, RG_AN3, RG_AN3, RG_S2, BR_NONE);
      6'd36: u = al(OP_ADD, RG_AN4, RG_T2, RG_T2, BR_NONE);
      6'd37: u = al(OP_ADD, RG_T1, RG_KQ, RG_B, BR_NONE);
      6'd38: u = al(OP_MUL, RG_AN4, RG_AN4, RG_T1, BR_NONE);
      6'd39: u = al(OP_MUL, RG_AN4, RG_AN4, RG_S2, BR_NONE);
      6'd40: u = al(OP_MUL, RG_T1, RG_AN3, RG_X, BR_NONE);
      6'd41: u = al(OP_ADD, RG_T1, RG_AN2, RG_T1, BR_NONE);
      6'd42: u = al(OP_DIV, RG_C1, RG_T1, RG_AN1, BR_NONE);
      6'd43: u = al(OP_DIV, RG_C2, RG_AN4, RG_AN1, BR_NONE);
      6'd44: u = al(OP_MUL, RG_T1, RG_C1, RG_P1, BR_NONE);
      6'd45: u = al(OP_MUL, RG_T2, RG_C2, RG_P0, BR_NONE);
      6'd46: u = al(OP_SUB, RG_T1, RG_T1, RG_T2, BR_NONE);
      6'd47: u = al(OP_ADD, RG_P0, RG_P1, RG_ZERO, BR_NONE);
      6'd48: u = al(OP_ADD, RG_P1, RG_T1, RG_ZERO, BR_STEP);
      6'd49: u = ld(RG_A, IM_ACFG, BR_NONE);
      6'd50: u = ld(RG_B, IM_BCFG, BR_NONE);
      6'd51: u = al(OP_ADD, RG_T1, RG_A, RG_B, BR_NONE);
      6'd52: u = ld(RG_T2, IM_NQ, BR_NONE);
      6'd53: u = al(OP_ADD, RG_T1, RG_T2, RG_T1, BR_NONE);
      6'd54: u = al(OP_ADD, RG_T1, RG_T1, RG_ONE, BR_NONE);
      6'd55: u = al(OP_MUL, RG_T1, RG_HALF, RG_T1, BR_NONE);
      6'd56: u = al(OP_MUL, RG_SLOPE, RG_T1, RG_P1, BR_END);
      default: u = ld(RG_ZERO, IM_ZERO, BR_END);
    endcase
    return u;
  endfunction

endpackage

/* design/jpe_alu.sv */
// Shared saturating Q32.32 arithmetic unit: add, subtract, multiply, divide.
// The multiply runs over four 32x32 partial products, the divide one bit a cycle.
// Depends on jpe_pkg.
module jpe_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  jpe_pkg::op_t  op,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [63:0]   result,
  output logic          sat
);

  logic         busy;
  logic         is_div;
  logic         neg;
  logic [7:0]   cnt;
  logic [63:0]  xm;
  logic [63:0]  ym;
  logic [63:0]  prod;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic [127:0] dvd;
  logic [127:0] quo;
  logic [63:0]  rem;

  logic [63:0]    sum;
  logic [63:0]    dif;
  logic [31:0]    xs;
  logic [31:0]    ys;
  logic [64:0]    trial;
  logic           fits;
  logic [127:0]   prod_sh;
  jpe_pkg::sat_res_t fm_mul;
  jpe_pkg::sat_res_t fm_div;

  assign sum = a + b;
  assign dif = a - b;
  assign xs = cnt[1] ? xm[63:32] : xm[31:0];
  assign ys = (cnt[1:0] == 2'd1 || cnt[1:0] == 2'd3) ? ym[63:32] : ym[31:0];
  assign trial = {rem, dvd[127]};
  assign fits = trial >= {1'b0, ym};
  assign fm_mul = jpe_pkg::from_mag(neg, acc[95:32]);
  assign fm_div = jpe_pkg::from_mag(neg, quo[63:0]);

  always_comb begin
    unique case (psh)
      2'd0: prod_sh = {64'd0, prod};
      2'd3: prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sat <= 1'b0;
        neg <= a[63] ^ b[63];
        xm <= jpe_pkg::mag_of(a);
        ym <= jpe_pkg::mag_of(b);
        cnt <= '0;
        unique case (op)
          jpe_pkg::OP_SUB: begin
            done <= 1'b1;
            if (a[63] != b[63] && dif[63] != a[63]) begin
              sat <= 1'b1;
              result <= a[63] ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
            end else begin
              result <= dif;
            end
          end
          jpe_pkg::OP_MUL: begin
            busy <= 1'b1;
            is_div <= 1'b0;
            acc <= '0;
          end
          jpe_pkg::OP_DIV: begin
            if (b == 64'd0) begin
              // A zero divisor saturates toward the sign of a nonzero numerator; zero over zero gives zero.
              done <= 1'b1;
              sat <= (a != 64'd0);
              result <= (a == 64'd0) ? 64'd0 : (a[63] ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX);
            end else begin
              busy <= 1'b1;
              is_div <= 1'b1;
              rem <= '0;
              quo <= '0;
              dvd <= {32'd0, jpe_pkg::mag_of(a), 32'd0};
            end
          end
          default: begin
            done <= 1'b1;
            if (a[63] == b[63] && sum[63] != a[63]) begin
              sat <= 1'b1;
              result <= a[63] ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
            end else begin
              result <= sum;
            end
          end
        endcase
      end else if (busy) begin
        cnt <= cnt + 8'd1;
        if (!is_div) begin
          if (cnt < 8'd4) begin
            prod <= 64'(xs) * 64'(ys);
            psh <= cnt[1:0];
          end
          if (cnt > 8'd0 && cnt < 8'd5) begin
            acc <= acc + prod_sh;
          end
          if (cnt == 8'd5) begin
            busy <= 1'b0;
            done <= 1'b1;
            if (acc[127:96] != 32'd0) begin
              sat <= 1'b1;
              result <= neg ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
            end else begin
              sat <= fm_mul.sat;
              result <= fm_mul.val;
            end
          end
        end else if (cnt < 8'd128) begin
          dvd <= {dvd[126:0], 1'b0};
          if (fits) begin
            rem <= 64'(trial - {1'b0, ym});
            quo <= {quo[126:0], 1'b1};
          end else begin
            rem <= trial[63:0];
            quo <= {quo[126:0], 1'b0};
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (quo[127:64] != 64'd0) begin
            sat <= 1'b1;
            result <= neg ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
          end else begin
            sat <= fm_div.sat;
            result <= fm_div.val;
          end
        end
      end
    end
  end

endmodule

/* design/jacobi_polynomial_evaluator.sv */
// Top level: APB registers, microprogram sequencer, register file and the shared unit.
// Depends on jpe_pkg and jpe_alu.
//
// An item is taken when start is high and busy is low; the result word appears for one
// cycle with done high and cannot be held off, so the receiver must take it then. Busy
// stays high for the whole evaluation. Every microprogram operation passes through read,
// issue and next states; a load writes the register file in its issue state, while an
// operation of the shared unit waits in the wait state and writes back when the unit is
// done. For orders of two or more the bit-serial divider takes most of the evaluation time.
module jacobi_polynomial_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  order,
  input  logic signed [31:0] point,
  output logic        done,
  output logic signed [63:0] poly_value,
  output logic signed [63:0] poly_slope,
  output logic        saturated
);

  localparam int KW = jpe_pkg::KW;

  jpe_pkg::state_t state;
  jpe_pkg::state_t state_next;
  jpe_pkg::uop_t   uop;

  logic [23:0] alpha_param;
  logic [23:0] beta_param;
  logic [31:0] point_q;
  logic [jpe_pkg::PC_W-1:0] pc;
  logic          pass;
  logic [KW-1:0] n;
  logic [KW-1:0] npass;
  logic [KW-1:0] k;
  logic [KW-1:0] n_clamp;
  logic          sat_flag;
  logic [63:0]   cur_p1;
  logic [63:0]   rf [32];
  logic [63:0]   rd_a;
  logic [63:0]   rd_b;
  logic [63:0]   imm_val;
  logic [63:0]   wr_data;
  logic          wr_en;
  logic          alu_start;
  logic          alu_done;
  logic          alu_sat;
  logic [63:0]   alu_result;
  logic          loop_more;
  logic          pass_end;
  logic          finish_all;

  assign uop = jpe_pkg::prog(pc);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == jpe_pkg::REG_BETA) ? {8'd0, beta_param} : {8'd0, alpha_param};
  assign busy = (state != jpe_pkg::ST_IDLE);
  assign saturated = sat_flag;
  assign n_clamp = (32'(order) > jpe_pkg::MAX_ORDER) ? KW'(jpe_pkg::MAX_ORDER) : KW'(order);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_param <= '0;
      beta_param <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == jpe_pkg::REG_BETA) begin
        beta_param <= pwdata[23:0];
      end else begin
        alpha_param <= pwdata[23:0];
      end
    end
  end

  always_comb begin
    unique case (uop.imm)
      jpe_pkg::IM_ONE:  imm_val = jpe_pkg::Q_ONE;
      jpe_pkg::IM_TWO:  imm_val = jpe_pkg::Q_TWO;
      jpe_pkg::IM_HALF: imm_val = jpe_pkg::Q_HALF;
      jpe_pkg::IM_X:    imm_val = {{30{point_q[31]}}, point_q, 2'b00};
      jpe_pkg::IM_ACFG: imm_val = {{24{alpha_param[23]}}, alpha_param, 16'd0};
      jpe_pkg::IM_BCFG: imm_val = {{24{beta_param[23]}}, beta_param, 16'd0};
      jpe_pkg::IM_KQ:   imm_val = 64'(k) << 32;
      jpe_pkg::IM_K2:   imm_val = 64'(k) << 33;
      jpe_pkg::IM_K12:  imm_val = (64'(k) + 64'd1) << 33;
      jpe_pkg::IM_NQ:   imm_val = 64'(n) << 32;
      default:          imm_val = 64'd0;
    endcase
  end

  // The recurrence keeps going while k+1 is still below the pass order.
  always_comb begin
    loop_more = ({1'b0, k} + 1'b1) < {1'b0, npass};
    unique case (uop.br)
      jpe_pkg::BR_PASS: pass_end = 1'b1;
      jpe_pkg::BR_INIT: pass_end = !(npass > KW'(1));
      jpe_pkg::BR_STEP: pass_end = !loop_more;
      default:          pass_end = 1'b0;
    endcase
    finish_all = (uop.br == jpe_pkg::BR_END) || (pass_end && !pass && n == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jpe_pkg::ST_IDLE:  if (start) state_next = jpe_pkg::ST_READ;
      jpe_pkg::ST_READ:  state_next = jpe_pkg::ST_ISSUE;
      jpe_pkg::ST_ISSUE: begin
        state_next = (uop.op == jpe_pkg::OP_LD) ? jpe_pkg::ST_NEXT : jpe_pkg::ST_WAIT;
      end
      jpe_pkg::ST_WAIT:  if (alu_done) state_next = jpe_pkg::ST_NEXT;
      jpe_pkg::ST_NEXT:  state_next = finish_all ? jpe_pkg::ST_DONE : jpe_pkg::ST_READ;
      default:           state_next = jpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    alu_start = (state == jpe_pkg::ST_ISSUE) && (uop.op != jpe_pkg::OP_LD);
    wr_en = ((state == jpe_pkg::ST_ISSUE) && (uop.op == jpe_pkg::OP_LD)) ||
            ((state == jpe_pkg::ST_WAIT) && alu_done);
    wr_data = (state == jpe_pkg::ST_WAIT) ? alu_result : imm_val;
    done = (state == jpe_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == jpe_pkg::ST_READ) begin
      rd_a <= rf[uop.sa];
      rd_b <= rf[uop.sb];
    end
    if (wr_en) begin
      rf[uop.dst] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      pass <= 1'b0;
      k <= '0;
      npass <= '0;
      n <= '0;
      sat_flag <= 1'b0;
    end else begin
      if (state == jpe_pkg::ST_IDLE && start) begin
        pc <= '0;
        pass <= 1'b0;
        n <= n_clamp;
        npass <= n_clamp;
        sat_flag <= 1'b0;
        point_q <= point;
        poly_slope <= '0;
      end
      if (state == jpe_pkg::ST_WAIT && alu_done) begin
        sat_flag <= sat_flag | alu_sat;
      end
      if (wr_en && uop.dst == jpe_pkg::RG_P1) begin
        cur_p1 <= wr_data;
      end
      if (wr_en && uop.dst == jpe_pkg::RG_SLOPE) begin
        poly_slope <= wr_data;
      end
      if (state == jpe_pkg::ST_NEXT) begin
        if (pass_end) begin
          if (!pass) begin
            poly_value <= cur_p1;
            pass <= 1'b1;
            npass <= n - KW'(1);
            pc <= jpe_pkg::L_PASS1;
          end else begin
            pc <= jpe_pkg::L_SLOPE;
          end
        end else begin
          unique case (uop.br)
            jpe_pkg::BR_SETUP: pc <= (npass == '0) ? jpe_pkg::L_ONE : jpe_pkg::L_INIT;
            jpe_pkg::BR_INIT: begin
              k <= KW'(1);
              pc <= jpe_pkg::L_STEP;
            end
            jpe_pkg::BR_STEP: begin
              k <= k + KW'(1);
              pc <= jpe_pkg::L_STEP;
            end
            default: pc <= pc + 1'b1;
          endcase
        end
      end
    end
  end

  jpe_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .op     (uop.op),
    .a      (rd_a),
    .b      (rd_b),
    .done   (alu_done),
    .result (alu_result),
    .sat    (alu_sat)
  );

endmodule

/* design/jpe_checker.sv */
// Port-level checker for the Jacobi polynomial evaluator, bound to the top level.
// Depends only on the ports of jacobi_polynomial_evaluator.
module jpe_assertions (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result word only comes out of an evaluation in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not start an evaluation");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block still busy after result");

endmodule

bind jacobi_polynomial_evaluator jpe_assertions u_jpe_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

/* tb/jpe_checker.sv */
// Checker for the Jacobi polynomial evaluator: watches the register port, the
// command words and the result words, predicts each result and compares it.
// Depends on jpe_pkg for the fixed-point constants.
module jpe_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        start,
  input  logic        busy,
  input  logic [6:0]  order,
  input  logic signed [31:0] point,
  input  logic        done,
  input  logic signed [63:0] poly_value,
  input  logic signed [63:0] poly_slope,
  input  logic        saturated,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] slope;
    logic        sat;
  } jpe_result_t;

  jpe_result_t result_queue[$];
  logic [23:0] alpha_shadow, beta_shadow;
  logic        ovf;

  assign pending = result_queue.size();

  function automatic logic [63:0] q_mag(logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] q_sign(logic neg, logic [63:0] mag);
    if (!neg) begin
      if (mag[63]) begin
        ovf = 1'b1;
        return jpe_pkg::Q_MAX;
      end
      return mag;
    end
    if (mag > jpe_pkg::Q_MIN) begin
      ovf = 1'b1;
      return jpe_pkg::Q_MIN;
    end
    return 64'd0 - mag;
  endfunction

  function automatic logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      ovf = 1'b1;
      return a[63] ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      ovf = 1'b1;
      return a[63] ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic         neg;
    neg = a[63] ^ b[63];
    p = {64'd0, q_mag(a)} * {64'd0, q_mag(b)};
    if (p[127:96] != 0) begin
      ovf = 1'b1;
      return neg ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
    end
    return q_sign(neg, p[95:32]);
  endfunction

  function automatic logic [63:0] q_div(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    logic         neg;
    if (den == 0) begin
      if (num == 0) return 64'd0;
      ovf = 1'b1;
      return num[63] ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
    end
    neg = num[63] ^ den[63];
    q = {32'd0, q_mag(num), 32'd0} / {64'd0, q_mag(den)};
    if (q[127:64] != 0) begin
      ovf = 1'b1;
      return neg ? jpe_pkg::Q_MIN : jpe_pkg::Q_MAX;
    end
    return q_sign(neg, q[63:0]);
  endfunction

  // Upward three-term recurrence from P0 and P1.
  function automatic logic [63:0] jacobi_at(int n, logic [63:0] a, logic [63:0] b,
                                            logic [63:0] x);
    logic [63:0] p0, p1, pn, ab, kq, s, s1, s2, ka, an1, an2, an3, an4, c1, c2;
    if (n == 0) return jpe_pkg::Q_ONE;
    p0 = jpe_pkg::Q_ONE;
    ab = q_add(a, b);
    p1 = q_mul(jpe_pkg::Q_HALF, q_add(q_sub(a, b), q_mul(q_add(ab, jpe_pkg::Q_TWO), x)));
    for (int k = 1; k < n; k++) begin
      kq = 64'(k) << 32;
      s = q_add(kq << 1, ab);
      s1 = q_add(s, jpe_pkg::Q_ONE);
      s2 = q_add(s, jpe_pkg::Q_TWO);
      ka = q_add(kq, a);
      an1 = q_mul(q_mul((kq + jpe_pkg::Q_ONE) << 1,
                        q_add(q_add(kq, ab), jpe_pkg::Q_ONE)), s);
      an2 = q_mul(s1, q_sub(q_mul(a, a), q_mul(b, b)));
      an3 = q_mul(q_mul(s, s1), s2);
      an4 = q_mul(q_mul(q_add(ka, ka), q_add(kq, b)), s2);
      c1 = q_div(q_add(an2, q_mul(an3, x)), an1);
      c2 = q_div(an4, an1);
      pn = q_sub(q_mul(c1, p1), q_mul(c2, p0));
      p0 = p1;
      p1 = pn;
    end
    return p1;
  endfunction

  function automatic jpe_result_t predict_jacobi(logic [6:0] ord, logic [31:0] pt);
    jpe_result_t r;
    logic [63:0] a, b, x, q, f;
    int n;
    ovf = 1'b0;
    n = (ord > jpe_pkg::MAX_ORDER) ? jpe_pkg::MAX_ORDER : int'(ord);
    a = {{24{alpha_shadow[23]}}, alpha_shadow, 16'd0};
    b = {{24{beta_shadow[23]}}, beta_shadow, 16'd0};
    x = {{30{pt[31]}}, pt, 2'b00};
    r.value = jacobi_at(n, a, b, x);
    r.slope = 64'd0;
    if (n > 0) begin
      q = jacobi_at(n - 1, q_add(a, jpe_pkg::Q_ONE), q_add(b, jpe_pkg::Q_ONE), x);
      f = q_add(q_add(64'(n) << 32, q_add(a, b)), jpe_pkg::Q_ONE);
      r.slope = q_mul(q_mul(jpe_pkg::Q_HALF, f), q);
    end
    r.sat = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    jpe_result_t want;
    if (rst) begin
      result_queue.delete();
      alpha_shadow <= 24'd0;
      beta_shadow <= 24'd0;
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2]) beta_shadow <= pwdata[23:0];
        else alpha_shadow <= pwdata[23:0];
      end
      if (start && !busy) result_queue.push_back(predict_jacobi(order, point));
      if (done) begin
        if (result_queue.size() == 0) begin
          if (fails < 10) $display("unexpected result word at %0t", $realtime);
          fails <= fails + 1;
        end else begin
          want = result_queue.pop_front();
          if (want.value !== poly_value || want.slope !== poly_slope ||
              want.sat !== saturated) begin
            if (fails < 10)
              $display("mismatch: value exp %h got %h, slope exp %h got %h, sat exp %b got %b",
                       want.value, poly_value, want.slope, poly_slope, want.sat, saturated);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/testbench.sv */
// Top of the Jacobi evaluator bench: clock, reset, register writes and command
// stimulus through several parameter phases. Depends on jpe_checker and the block.
module testbench;
  localparam logic [2:0] ADDR_ALPHA = 3'd0;
  localparam logic [2:0] ADDR_BETA = 3'd4;
  localparam int IDLE_LIMIT = 200000;

  logic clk, rst, psel, penable, pwrite, pready, start, busy, done, saturated;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic [6:0]  order;
  logic signed [31:0] point;
  logic signed [63:0] poly_value, poly_slope;
  int fails, pending, quiet_cycles, idle_pct;

  jacobi_polynomial_evaluator dut (.*);
  jpe_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [23:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= {{8{value[23]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(logic [6:0] ord, logic [31:0] pt);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk);
      @(posedge clk);
    end
    start <= 1'b1;
    order <= ord;
    point <= pt;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_random;
    int r;
    logic [6:0] ord;
    logic [31:0] pt;
    r = $urandom_range(99);
    // Mostly low orders; each recurrence step includes two bit-serial divides.
    if (r < 45) ord = 7'($urandom_range(3));
    else if (r < 95) ord = 7'($urandom_range(8, 4));
    else if (r < 99) ord = 7'($urandom_range(20, 9));
    else ord = 7'($urandom_range(127, 21));
    if ($urandom_range(99) < 85) pt = $urandom_range(32'h8000_0000) - 32'h4000_0000;
    else pt = $urandom;
    send_word(ord, pt);
  endtask

  task automatic set_params(logic [23:0] a, logic [23:0] b);
    reg_write(ADDR_ALPHA, a);
    reg_write(ADDR_BETA, b);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    start = 1'b0;
    order = 7'd0;
    point = 32'sd0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset parameters: degree zero, the clamp above the maximum order, and edge points.
    send_word(7'd0, 32'h4000_0000);
    send_word(7'd1, 32'hC000_0000);
    send_word(7'd2, 32'h0000_0000);
    send_word(7'd3, 32'h7FFF_FFFF);
    send_word(7'd2, 32'h8000_0000);
    send_word(7'd64, 32'h2000_0000);
    send_word(7'd127, 32'hE000_0000);
    send_word(7'd65, 32'h4000_0000);
    send_word(7'd5, $urandom);
    drain();

    set_params(24'hFF0001, 24'hFF0001);   // both just above minus one
    send_word(7'd0, 32'h4000_0000);
    send_word(7'd4, 32'hC000_0000);
    send_word(7'd3, 32'h1234_5678);
    drain();
    set_params(24'h400000, 24'h000000);   // alpha at its upper bound
    send_word(7'd3, 32'h4000_0000);
    send_word(7'd6, 32'hC000_0000);
    drain();
    set_params(24'h7FFFFF, 24'h800000);   // field extremes, far outside the meaningful range
    send_word(7'd2, 32'h4000_0000);
    send_word(7'd4, 32'hFFFF_FFFF);
    send_word(7'd1, 32'h0000_0001);
    drain();
    set_params(24'hFF0000, 24'hFF0000);   // alpha plus beta makes a zero divisor
    send_word(7'd3, 32'h2000_0000);
    send_word(7'd2, 32'h0000_0000);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_params(24'd0, 24'd0);
        1: set_params(24'h400000, 24'h400000);
        2: set_params(24'hFF0001, 24'h400000);
        default: set_params(24'($urandom_range(4194304 + 65535) - 65535),
                            24'($urandom_range(4194304 + 65535) - 65535));
      endcase
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 68;
        2: idle_pct = 0;
        default: idle_pct = 21;
      endcase
      repeat (48) send_random();
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
